### rtl/random_pick_and_compact_shuffle_core_defines.svh
// Assertion helpers used by the checker file.
`ifndef RANDOM_PICK_AND_COMPACT_SHUFFLE_CORE_DEFINES_SVH
`define RANDOM_PICK_AND_COMPACT_SHUFFLE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RPCS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RPCS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that stays checked through reset.
`define RPCS_ASSERT_NXT_ANY(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/rpcs_pkg.sv
package rpcs_pkg;

  localparam int DEPTH_DEF   = 1024;
  localparam int ELEM_W      = 32;
  localparam int RAND_W      = 31;
  localparam int IN_TDATA_W  = ((ELEM_W + RAND_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((ELEM_W + 7) / 8) * 8;

  // Command carried in s_tuser
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_DRAW = 1'b1
  } cmd_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_TREE,
    ST_EMIT
  } state_t;

  // Broadcast control for the row of cells
  typedef struct packed {
    logic load;   // write element into the cell at the fill position
    logic shift;  // cells at or above the pick index take their upper neighbor
  } cell_ctrl_t;

endpackage

### rtl/random_pick_and_compact_shuffle_core.sv
// Random pick-and-compact table: a load (s_tuser = 0) appends one element to
// a row of DEPTH cells, or is dropped when the row is full, and gives no
// result. A draw (s_tuser = 1) reduces its random number modulo the element
// count with a bit-serial remainder unit, picks the element at that index
// through a registered OR tree, outputs it and closes the gap by shifting
// every higher cell down one place. One item is worked on at a time, and the
// output register lets the next item be taken while a result waits. A draw
// on an empty row returns zero with m_tuser set, and m_tlast marks the draw
// that empties the row. The cells come up with undefined contents.
module random_pick_and_compact_shuffle_core
  import rpcs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int CW   = $clog2(DEPTH + 1),
  localparam int IW   = $clog2(DEPTH),
  localparam int LAT  = $clog2(DEPTH),
  localparam int TW   = $clog2(LAT + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // element[31:0], random_value[62:32], zero pad
  input  logic                   s_tuser,   // cmd: 0 load, 1 draw
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // picked[31:0]
  output logic                   m_tlast,   // last
  output logic                   m_tuser    // empty_error
);

  state_t            state, state_next;
  cell_ctrl_t        ctrl;
  logic [CW-1:0]     count;
  logic [IW-1:0]     pick_idx;
  logic [TW-1:0]     wait_cnt;
  logic              mod_start;
  logic              mod_done;
  logic [IW-1:0]     mod_rem;
  logic              in_xfer;
  logic              out_free;
  logic [ELEM_W-1:0] in_elem;
  logic [RAND_W-1:0] in_rand;
  logic [ELEM_W-1:0] res_pick;
  logic              res_last;
  logic              res_err;
  logic [ELEM_W-1:0] root;
  logic [ELEM_W-1:0] cell_data [DEPTH];
  logic [ELEM_W-1:0] leaves    [DEPTH];

  assign in_elem  = s_tdata[ELEM_W-1:0];
  assign in_rand  = s_tdata[ELEM_W+RAND_W-1:ELEM_W];
  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and cell control
  always_comb begin
    state_next = state;
    mod_start  = 1'b0;
    ctrl       = '0;
    s_tready   = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          if (s_tuser == CMD_DRAW) begin
            if (count == '0) begin
              state_next = ST_EMIT;
            end else begin
              mod_start  = 1'b1;
              state_next = ST_DIV;
            end
          end else if (count < CW'(DEPTH)) begin
            ctrl.load = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (mod_done) begin
          state_next = ST_TREE;
        end
      end
      ST_TREE: begin
        if (wait_cnt == TW'(LAT)) begin
          ctrl.shift = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Track the element count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.load) begin
      count <= count + CW'(1);
    end else if (ctrl.shift) begin
      count <= count - CW'(1);
    end
  end

  // Latch the pick index and time the tree latency
  always_ff @(posedge clk) begin
    if (mod_done) begin
      pick_idx <= mod_rem;
      wait_cnt <= '0;
    end else if (state == ST_TREE) begin
      wait_cnt <= wait_cnt + TW'(1);
    end
  end

  // Capture the result of a draw
  always_ff @(posedge clk) begin
    if (in_xfer && (s_tuser == CMD_DRAW) && (count == '0)) begin
      res_pick <= '0;
      res_last <= 1'b0;
      res_err  <= 1'b1;
    end else if (ctrl.shift) begin
      res_pick <= root;
      res_last <= (count == CW'(1));
      res_err  <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_EMIT) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && out_free) begin
      m_tdata <= OUT_TDATA_W'(res_pick);
      m_tlast <= res_last;
      m_tuser <= res_err;
    end
  end

  rpcs_mod #(.DEPTH(DEPTH)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (in_rand),
    .divisor  (count),
    .done     (mod_done),
    .rem_out  (mod_rem)
  );

  // Row of cells, each fed by its upper neighbor
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [ELEM_W-1:0] nbr;
    if (k == DEPTH - 1) begin : g_top
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_data[k+1];
    end
    rpcs_cell #(.DEPTH(DEPTH), .IDX(k)) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .count    (count),
      .pick_idx (pick_idx),
      .element  (in_elem),
      .nbr_data (nbr),
      .data     (cell_data[k]),
      .leaf     (leaves[k])
    );
  end

  rpcs_tree #(.DEPTH(DEPTH)) u_tree (
    .clk    (clk),
    .leaves (leaves),
    .root   (root)
  );

endmodule

### rtl/rpcs_cell.sv
module rpcs_cell
  import rpcs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int IDX   = 0,
  localparam int CW   = $clog2(DEPTH + 1),
  localparam int IW   = $clog2(DEPTH)
) (
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic [CW-1:0]     count,
  input  logic [IW-1:0]     pick_idx,
  input  logic [ELEM_W-1:0] element,
  input  logic [ELEM_W-1:0] nbr_data,
  output logic [ELEM_W-1:0] data,
  output logic [ELEM_W-1:0] leaf
);

  // Load at the fill position, or close the gap by taking the upper neighbor
  always_ff @(posedge clk) begin
    if (ctrl.load && (count == CW'(IDX))) begin
      data <= element;
    end else if (ctrl.shift && (IW'(IDX) >= pick_idx)) begin
      data <= nbr_data;
    end
  end

  // Offer the value to the reduction tree only when this cell is picked
  assign leaf = (IW'(IDX) == pick_idx) ? data : '0;

endmodule

### rtl/rpcs_tree.sv
module rpcs_tree
  import rpcs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int LG   = $clog2(DEPTH),
  localparam int N    = 1 << LG
) (
  input  logic              clk,
  input  logic [ELEM_W-1:0] leaves [DEPTH],
  output logic [ELEM_W-1:0] root
);

  logic [ELEM_W-1:0] node [N-1];

  // Registered OR tree in heap order; every path from a leaf is LG stages
  for (genvar i = 0; i < N - 1; i++) begin : g_node
    localparam int C0 = 2 * i + 1;
    localparam int C1 = 2 * i + 2;
    logic [ELEM_W-1:0] a;
    logic [ELEM_W-1:0] b;

    if (C0 >= N - 1) begin : g_leaf0
      if (C0 - (N - 1) < DEPTH) begin : g_in
        assign a = leaves[C0 - (N - 1)];
      end else begin : g_pad
        assign a = '0;
      end
    end else begin : g_int0
      assign a = node[C0];
    end

    if (C1 >= N - 1) begin : g_leaf1
      if (C1 - (N - 1) < DEPTH) begin : g_in
        assign b = leaves[C1 - (N - 1)];
      end else begin : g_pad
        assign b = '0;
      end
    end else begin : g_int1
      assign b = node[C1];
    end

    always_ff @(posedge clk) begin
      node[i] <= a | b;
    end
  end

  assign root = node[0];

endmodule

### rtl/rpcs_mod.sv
module rpcs_mod
  import rpcs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int CW   = $clog2(DEPTH + 1),
  localparam int IW   = $clog2(DEPTH),
  localparam int SW   = $clog2(RAND_W + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAND_W-1:0] dividend,
  input  logic [CW-1:0]     divisor,
  output logic              done,
  output logic [IW-1:0]     rem_out
);

  logic [RAND_W-1:0] dvd;
  logic [CW-1:0]     rem;
  logic [CW-1:0]     dsr;
  logic [SW-1:0]     steps;
  logic              busy;
  logic [CW:0]       trial;
  logic              fits;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  assign trial = {rem, dvd[RAND_W-1]};
  assign fits  = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (steps == SW'(1))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd   <= dividend;
      dsr   <= divisor;
      rem   <= '0;
      steps <= SW'(RAND_W);
    end else if (busy) begin
      dvd   <= dvd << 1;
      rem   <= fits ? CW'(trial - {1'b0, dsr}) : trial[CW-1:0];
      steps <= steps - SW'(1);
    end
  end

  // Remainder stays below the divisor, which never exceeds DEPTH
  assign rem_out = rem[IW-1:0];

endmodule

### rtl/rpcs_checker.sv
`include "random_pick_and_compact_shuffle_core_defines.svh"

module rpcs_checker
  import rpcs_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   s_tuser,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic                   m_tlast,
  input logic                   m_tuser
);

  // A stalled result holds its payload
  `RPCS_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled result changed")

  // An empty-store result carries zero and no last mark
  `RPCS_ASSERT_IMP(a_err_zero, clk, rst, m_tvalid && m_tuser, (m_tdata == '0) && !m_tlast, "error result not zero")

  // A draw transfer holds off the next input
  `RPCS_ASSERT_NXT(a_draw_busy, clk, rst, s_tvalid && s_tready && (s_tuser == CMD_DRAW), !s_tready, "input taken during a draw")

  // Reset leaves no result pending
  `RPCS_ASSERT_NXT_ANY(a_rst_idle, clk, rst, !m_tvalid, "result valid after reset")

endmodule

bind random_pick_and_compact_shuffle_core rpcs_checker u_rpcs_checker (.*);

### test/tb.sv
`timescale 1ns / 1ps

module tb;
  import rpcs_pkg::*;

  // One item offered on the slave side; hold_for_drain stalls it until no pick is due
  typedef struct packed {
    logic          hold_for_drain;
    cmd_t          cmd;
    logic [31:0]   elem;
    logic [30:0]   rnd;
  } send_item_t;

  // One expected draw result
  typedef struct packed {
    logic [31:0] picked;
    logic        last;
    logic        empty_err;
  } pick_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // element[31:0], random_value[62:32], zero pad
  logic                   s_tuser = 1'b0; // cmd
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // picked[31:0]
  logic                   m_tlast;        // last
  logic                   m_tuser;        // empty_error

  send_item_t  items_to_send[$];
  pick_t       due_picks[$];
  logic [31:0] shelf[$];       // predicted contents of the row of cells

  bit in_took = 1'b0;
  int est_fill = 0;            // fill level as the stimulus generator sees it
  int draws_taken = 0;
  int bad_count = 0;
  int tx_gap = 0;
  int rx_gap = 0;
  int choke_left = 0;
  int chokes_done = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int choke_mark[2] = '{12, 28};

  random_pick_and_compact_shuffle_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, a few long ones, none in a steady stretch
  function automatic int idle_len(bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  // Random number for a draw: small, near the top, or anywhere
  function automatic logic [30:0] pick_rnd();
    int sel;
    logic [30:0] v;
    sel = $urandom_range(0, 7);
    if (sel == 0) v = 31'($urandom_range(0, 15));
    else if (sel == 1) v = 31'h7FFF_FFFF - 31'($urandom_range(0, 15));
    else v = 31'($urandom);
    return v;
  endfunction

  task automatic queue_item(bit hold, cmd_t c, logic [31:0] e, logic [30:0] r);
    send_item_t it;
    it.hold_for_drain = hold;
    it.cmd = c;
    it.elem = e;
    it.rnd = r;
    items_to_send.push_back(it);
    if (c == CMD_LOAD && est_fill < DEPTH_DEF) est_fill++;
    else if (c == CMD_DRAW && est_fill > 0) est_fill--;
  endtask

  // Predict the effect of one accepted transfer
  task automatic model_transfer(cmd_t c, logic [31:0] e, logic [30:0] r);
    pick_t res;
    int slot;
    if (c == CMD_LOAD) begin
      // drop the element when the row is full
      if (shelf.size() < DEPTH_DEF) shelf.push_back(e);
    end else begin
      draws_taken++;
      if (shelf.size() == 0) begin
        res.picked = '0;
        res.last = 1'b0;
        res.empty_err = 1'b1;
      end else begin
        slot = int'({1'b0, r} % 32'(shelf.size()));
        res.picked = shelf[slot];
        shelf.delete(slot);
        res.last = (shelf.size() == 0);
        res.empty_err = 1'b0;
      end
      due_picks.push_back(res);
    end
  endtask

  // Slave-side driver: advance to the next item once the current one is taken
  always @(negedge clk) begin : drive
    send_item_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_took) begin
      if (tx_gap > 0) begin
        tx_gap--;
        s_tvalid <= 1'b0;
      end else if (items_to_send.size() != 0 &&
                   !(items_to_send[0].hold_for_drain && due_picks.size() != 0)) begin
        nxt = items_to_send.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= nxt.cmd;
        s_tdata  <= {1'b0, nxt.rnd, nxt.elem};
        if ($urandom_range(0, 49) == 0) tx_steady = !tx_steady;
        tx_gap = idle_len(tx_steady);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Master-side ready: random stalls, plus long hold-offs to back up the block
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (choke_left > 0) begin
      choke_left--;
      m_tready <= 1'b0;
    end else if (chokes_done < 2 && draws_taken >= choke_mark[chokes_done]) begin
      choke_left = 400;
      chokes_done++;
      m_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 59) == 0) rx_steady = !rx_steady;
      if ($urandom_range(0, 4) == 0) rx_gap = idle_len(rx_steady);
    end
  end

  // Monitor: predict on input transfers, check output transfers
  always @(posedge clk) begin : watch
    pick_t want;
    pick_t got;
    in_took = 1'b0;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        in_took = 1'b1;
        model_transfer(cmd_t'(s_tuser), s_tdata[31:0], s_tdata[62:32]);
      end
      if (m_tvalid && m_tready) begin
        got.picked = m_tdata[31:0];
        got.last = m_tlast;
        got.empty_err = m_tuser;
        if (due_picks.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("unexpected result: picked %h last %0b empty_error %0b",
                     got.picked, got.last, got.empty_err);
        end else begin
          want = due_picks.pop_front();
          if (got !== want) begin
            bad_count++;
            if (bad_count <= 10)
              $display("mismatch (exp/act): picked %h/%h last %0b/%0b empty_error %0b/%0b",
                       want.picked, got.picked, want.last, got.last,
                       want.empty_err, got.empty_err);
          end
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

  initial begin : stimulus
    int n;
    int extra;
    int sent;

    // Draws on an empty row, a single element, then corner values
    queue_item(1'b0, CMD_DRAW, 32'h0, 31'h0);
    queue_item(1'b0, CMD_DRAW, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    queue_item(1'b0, CMD_LOAD, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    queue_item(1'b0, CMD_DRAW, 32'h0, 31'h7FFF_FFFF);
    queue_item(1'b0, CMD_LOAD, 32'h8000_0000, 31'h0);
    queue_item(1'b0, CMD_LOAD, 32'hFFFF_FFFF, 31'h5555_5555);
    queue_item(1'b0, CMD_LOAD, 32'h0000_0000, 31'h2AAA_AAAA);
    queue_item(1'b0, CMD_LOAD, 32'h0000_0001, 31'h0);
    queue_item(1'b0, CMD_LOAD, 32'h5555_5555, 31'h7FFF_FFFF);
    queue_item(1'b0, CMD_DRAW, 32'h0, 31'h7FFF_FFFF);
    queue_item(1'b0, CMD_DRAW, 32'hAAAA_AAAA, 31'h0);
    queue_item(1'b0, CMD_DRAW, 32'h0, 31'h2AAA_AAAA);
    queue_item(1'b0, CMD_DRAW, 32'h0, 31'h5555_5555);
    queue_item(1'b0, CMD_DRAW, 32'h0, 31'h1);
    queue_item(1'b0, CMD_DRAW, 32'h0, 31'h1234_5678);

    // Rounds: load a batch, then draw it down, with some noise in between
    sent = 0;
    while (sent < 40) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 20);
      for (int i = 0; i < n; i++)
        queue_item(i == 0 && $urandom_range(0, 3) == 0, CMD_LOAD, $urandom, pick_rnd());
      sent += n;
      if ($urandom_range(0, 3) == 0) begin
        extra = $urandom_range(1, 6);
        for (int i = 0; i < extra; i++)
          queue_item(1'b0, cmd_t'($urandom_range(0, 1)), $urandom, pick_rnd());
        sent += extra;
      end
      extra = ($urandom_range(0, 3) == 0) ? est_fill / 2
                                          : est_fill + ($urandom_range(0, 4) == 0);
      for (int i = 0; i < extra; i++)
        queue_item(1'b0, CMD_DRAW, $urandom, pick_rnd());
      sent += extra;
    end

    // Fill the row to the top, push loads past it, then work near full
    queue_item(1'b1, CMD_LOAD, $urandom, pick_rnd());
    while (est_fill < DEPTH_DEF)
      queue_item(1'b0, CMD_LOAD, $urandom, pick_rnd());
    for (int i = 0; i < 3; i++)
      queue_item(1'b0, CMD_LOAD, $urandom, pick_rnd());
    for (int i = 0; i < 10; i++) begin
      queue_item(1'b0, CMD_DRAW, $urandom, pick_rnd());
      queue_item(1'b0, CMD_LOAD, $urandom, pick_rnd());
      queue_item(1'b0, CMD_LOAD, $urandom, pick_rnd());
    end
    for (int i = 0; i < 10; i++)
      queue_item(1'b0, CMD_DRAW, $urandom, pick_rnd());

    // Hold reset, then release it on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for every item to go in and every pick to come out
    while (items_to_send.size() != 0 || s_tvalid) @(posedge clk);
    while (due_picks.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    if (bad_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/rpcs_pkg.sv
rtl/rpcs_cell.sv
rtl/rpcs_tree.sv
rtl/rpcs_mod.sv
rtl/random_pick_and_compact_shuffle_core.sv
rtl/rpcs_checker.sv
test/tb.sv
